FILE: sv/pfp_pkg.sv
// Shared constants for the pressure frame parser.
`timescale 1ns / 1ps

package pfp_pkg;

    localparam logic [7:0] SYNC_BYTE    = 8'hff;
    localparam logic [7:0] HDR9_FIRST   = 8'h25;
    localparam logic [7:0] HDR9_SECOND  = 8'h4f;
    localparam logic [7:0] HDR13_FIRST  = 8'h29;
    localparam logic [7:0] HDR13_SECOND = 8'hcf;

    localparam int NINE_LEN     = 9;
    localparam int THIRTEEN_LEN = 13;

    localparam int PRESSURE_COUNT = 5;
    localparam int NINE_PRESS_BASE     = 3;
    localparam int THIRTEEN_PRESS_BASE = 7;
    localparam int LAST_KEPT_INDEX     = 11;

    localparam logic FRAME_KIND_NINE     = 1'b0;
    localparam logic FRAME_KIND_THIRTEEN = 1'b1;
    localparam logic CHECK_OK            = 1'b0;
    localparam logic CHECK_ERROR         = 1'b1;

    typedef logic [7:0] pressure_t;

    localparam pressure_t PRESSURE_INIT [PRESSURE_COUNT] =
        '{8'd1, 8'd2, 8'd3, 8'd4, 8'd12};

endpackage

FILE: sv/pressure_frame_parser.sv
// Top level: serial pressure frame parser with registered input and result stages.
`timescale 1ns / 1ps

// Takes one received byte per beat and accepts a new byte in every cycle while the
// result register is free or being drained. A byte is registered at the input and
// processed once the result register is free or being drained; a frame's result beat
// is registered for the master side. Byte 0xff starts a frame; other bytes before
// sync are dropped. A nine-byte frame with header 25 4F or a thirteen-byte frame with
// header 29 CF gives one result beat carrying the frame kind, the checksum status and
// the five held pressures (updated only when the checksum is good). A running checksum
// and a position counter that wraps at STORE_DEPTH keep the per-byte work to one add
// and a few compares. Only frame bytes one through eleven are ever read back, so
// those are kept in registers.
module pressure_frame_parser #(
    parameter int STORE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] corner_pressure_0, [15:8] corner_pressure_1,
                                   // [23:16] corner_pressure_2, [31:24] corner_pressure_3,
                                   // [39:32] tank_pressure
    output logic [1:0]  m_tuser    // [0] frame_kind, [1] check_status
);

    localparam int PW = $clog2(STORE_DEPTH);

    logic                 in_valid_reg;
    logic [7:0]           rx_reg;
    logic [PW-1:0]        pos_reg;
    logic [PW-1:0]        pos_next;
    logic [PW-1:0]        pos_inc;
    logic [7:0]           sum_reg;
    logic [7:0]           sum_next;
    pfp_pkg::pressure_t   store_reg [1:pfp_pkg::LAST_KEPT_INDEX];
    pfp_pkg::pressure_t   held_reg  [pfp_pkg::PRESSURE_COUNT];
    pfp_pkg::pressure_t   frame_press [pfp_pkg::PRESSURE_COUNT];
    pfp_pkg::pressure_t   out_press   [pfp_pkg::PRESSURE_COUNT];
    logic                 m_tvalid_reg;
    logic [39:0]          m_tdata_reg;
    logic [1:0]           m_tuser_reg;

    logic out_free;
    logic proc;
    logic store_en;
    logic hdr9;
    logic hdr13;
    logic res_hit;
    logic res_kind;
    logic res_good;

    assign out_free = !m_tvalid_reg || m_tready;
    assign proc     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign hdr9  = (store_reg[1] == pfp_pkg::HDR9_FIRST)  && (store_reg[2] == pfp_pkg::HDR9_SECOND);
    assign hdr13 = (store_reg[1] == pfp_pkg::HDR13_FIRST) && (store_reg[2] == pfp_pkg::HDR13_SECOND);

    always_comb
    begin
        pos_inc  = (pos_reg == PW'(STORE_DEPTH - 1)) ? '0 : pos_reg + PW'(1);
        pos_next = pos_reg;
        sum_next = sum_reg;
        store_en = 1'b0;
        res_hit  = 1'b0;
        res_kind = pfp_pkg::FRAME_KIND_NINE;
        res_good = 1'b0;
        if (proc)
        begin
            if (rx_reg == pfp_pkg::SYNC_BYTE)
            begin
                pos_next = PW'(1);
                sum_next = '0;
            end
            else if (pos_reg != '0)
            begin
                store_en = 1'b1;
                sum_next = sum_reg + rx_reg;
                pos_next = pos_inc;
                if (pos_inc == PW'(pfp_pkg::NINE_LEN) && hdr9)
                begin
                    res_hit  = 1'b1;
                    res_kind = pfp_pkg::FRAME_KIND_NINE;
                    res_good = (sum_next == 8'd0);
                end
                else if (pos_inc == PW'(pfp_pkg::THIRTEEN_LEN) && hdr13)
                begin
                    res_hit  = 1'b1;
                    res_kind = pfp_pkg::FRAME_KIND_THIRTEEN;
                    res_good = (sum_next == 8'd0);
                    pos_next = '0;
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < pfp_pkg::PRESSURE_COUNT; i++)
        begin
            frame_press[i] = res_kind ? store_reg[pfp_pkg::THIRTEEN_PRESS_BASE + i]
                                      : store_reg[pfp_pkg::NINE_PRESS_BASE + i];
            out_press[i]   = res_good ? frame_press[i] : held_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            pos_reg      <= '0;
            sum_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < pfp_pkg::PRESSURE_COUNT; i++)
            begin
                held_reg[i] <= pfp_pkg::PRESSURE_INIT[i];
            end
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            pos_reg <= pos_next;
            sum_reg <= sum_next;
            if (res_hit)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (res_hit && res_good)
            begin
                for (int i = 0; i < pfp_pkg::PRESSURE_COUNT; i++)
                begin
                    held_reg[i] <= frame_press[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            rx_reg <= s_tdata;
        end
        for (int i = 1; i <= pfp_pkg::LAST_KEPT_INDEX; i++)
        begin
            if (store_en && pos_reg == PW'(i))
            begin
                store_reg[i] <= rx_reg;
            end
        end
        if (res_hit)
        begin
            m_tdata_reg <= {out_press[4], out_press[3], out_press[2], out_press[1], out_press[0]};
            m_tuser_reg <= {res_good ? pfp_pkg::CHECK_OK : pfp_pkg::CHECK_ERROR, res_kind};
        end
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PW'(STORE_DEPTH - 1))
        else $error("position out of range");

    a_out_matches_held: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> m_tdata_reg == {held_reg[4], held_reg[3], held_reg[2],
                                         held_reg[1], held_reg[0]})
        else $error("result pressures differ from held pressures");

    a_thirteen_clears: assert property (@(posedge clk) disable iff (!rst_n)
        res_hit && res_kind == pfp_pkg::FRAME_KIND_THIRTEEN |=> pos_reg == '0)
        else $error("thirteen-byte frame did not clear position");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input stage empty but not ready");

    a_result_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(in_valid_reg))
        else $error("result without a processed beat");

endmodule

FILE: tb/tb_pressure_frame_parser.sv
// Self-checking testbench for the pressure frame parser: random framed byte streams, scoreboard.
`timescale 1ns / 1ps

module tb_pressure_frame_parser;

    localparam int STORE_DEPTH    = 16;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef enum int {
        FRAME_CLEAN,
        FRAME_BAD_SUM,
        FRAME_BAD_HEADER,
        FRAME_CUT
    } frame_flaw_t;

    typedef struct packed {
        logic                                               check_status;
        logic                                               frame_kind;
        pfp_pkg::pressure_t [pfp_pkg::PRESSURE_COUNT-1:0]   press;
    } frame_result_t;

    class pressure_scoreboard;
        logic [7:0]          frame_bytes [STORE_DEPTH];
        int unsigned         position;
        pfp_pkg::pressure_t  held [pfp_pkg::PRESSURE_COUNT];
        frame_result_t       pending [$];
        int unsigned         failures;

        function new();
            position = 0;
            failures = 0;
            foreach (held[i]) held[i] = pfp_pkg::PRESSURE_INIT[i];
            foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
        endfunction

        function bit checksum_ok(int unsigned len);
            logic [7:0]  total;
            int unsigned i;
            total = 8'h00;
            for (i = 1; i + 1 < len; i++) total = total + frame_bytes[i % STORE_DEPTH];
            return frame_bytes[(len - 1) % STORE_DEPTH] == 8'(8'h00 - total);
        endfunction

        function void post(logic kind, bit good);
            frame_result_t r;
            int            i;
            r.frame_kind   = kind;
            r.check_status = good ? pfp_pkg::CHECK_OK : pfp_pkg::CHECK_ERROR;
            for (i = 0; i < pfp_pkg::PRESSURE_COUNT; i++) r.press[i] = held[i];
            pending.push_back(r);
        endfunction

        function void note_byte(logic [7:0] value);
            bit good;
            int i;
            if (value == pfp_pkg::SYNC_BYTE) position = 0;
            else if (position == 0) return;
            frame_bytes[position % STORE_DEPTH] = value;
            position = (position + 1) % STORE_DEPTH;
            if (position == pfp_pkg::NINE_LEN && frame_bytes[1] == pfp_pkg::HDR9_FIRST
                    && frame_bytes[2] == pfp_pkg::HDR9_SECOND)
            begin
                good = checksum_ok(pfp_pkg::NINE_LEN);
                if (good)
                    for (i = 0; i < pfp_pkg::PRESSURE_COUNT; i++)
                        held[i] = frame_bytes[i + pfp_pkg::NINE_PRESS_BASE];
                post(pfp_pkg::FRAME_KIND_NINE, good);
            end
            else if (position == pfp_pkg::THIRTEEN_LEN && frame_bytes[1] == pfp_pkg::HDR13_FIRST
                    && frame_bytes[2] == pfp_pkg::HDR13_SECOND)
            begin
                good = checksum_ok(pfp_pkg::THIRTEEN_LEN);
                if (good)
                    for (i = 0; i < pfp_pkg::PRESSURE_COUNT; i++)
                        held[i] = frame_bytes[(i + pfp_pkg::THIRTEEN_PRESS_BASE) % STORE_DEPTH];
                position = 0;
                post(pfp_pkg::FRAME_KIND_THIRTEEN, good);
            end
        endfunction

        function bit log_failure();
            failures++;
            return failures <= 10;
        endfunction

        function void check_result(logic [39:0] data, logic [1:0] user);
            frame_result_t exp;
            if (pending.size() == 0)
            begin
                if (log_failure())
                    $display("unexpected result beat: kind %0d status %0d press %h",
                             user[0], user[1], data);
                return;
            end
            exp = pending.pop_front();
            if (user[0] != exp.frame_kind || user[1] != exp.check_status
                    || data != exp.press)
            begin
                if (log_failure())
                    $display({"result beat differs: exp kind %0d status %0d press %h, ",
                              "got kind %0d status %0d press %h"},
                             exp.frame_kind, exp.check_status, exp.press,
                             user[0], user[1], data);
            end
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned frame_beats    = 0;
    int unsigned hold_left      = 0;
    bit          hold_request   = 1'b0;

    pressure_scoreboard sb = new();

    pressure_frame_parser #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready) sb.note_byte(s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
        end
    end

    // hold off the receiver for a long stretch on request, else stall at random
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("pressure_frame_parser: mismatch");
        $finish;
    end

    function automatic logic [7:0] rand_data();
        return 8'($urandom_range(254));
    endfunction

    task automatic send_byte(input logic [7:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic send_run(input int unsigned count, input bit allow_sync);
        int unsigned i;
        for (i = 0; i < count; i++)
            send_byte(allow_sync ? 8'($urandom_range(255)) : rand_data());
    endtask

    // fill: fixed body value when fixed is set, else random non-sync bytes
    task automatic send_frame(input bit thirteen, input frame_flaw_t flaw,
                              input bit fixed, input logic [7:0] fill);
        logic [7:0]  fb [pfp_pkg::THIRTEEN_LEN];
        logic [7:0]  cks;
        int unsigned len;
        int unsigned cut;
        int unsigned i;
        int unsigned h;
        len   = thirteen ? pfp_pkg::THIRTEEN_LEN : pfp_pkg::NINE_LEN;
        fb[0] = pfp_pkg::SYNC_BYTE;
        fb[1] = thirteen ? pfp_pkg::HDR13_FIRST : pfp_pkg::HDR9_FIRST;
        fb[2] = thirteen ? pfp_pkg::HDR13_SECOND : pfp_pkg::HDR9_SECOND;
        for (i = 3; i < len - 1; i++) fb[i] = fixed ? fill : rand_data();
        if (flaw == FRAME_BAD_HEADER)
        begin
            h     = 1 + $urandom_range(1);
            fb[h] = fb[h] ^ 8'($urandom_range(1, 255));
            if (fb[h] == pfp_pkg::SYNC_BYTE) fb[h] = 8'h00;
        end
        forever
        begin
            cks = 8'h00;
            for (i = 1; i < len - 1; i++) cks = cks - fb[i];
            if (cks != pfp_pkg::SYNC_BYTE || fixed) break;
            fb[3] = rand_data();
        end
        fb[len - 1] = cks;
        if (flaw == FRAME_BAD_SUM)
        begin
            fb[len - 1] = cks + 8'($urandom_range(1, 254));
            if (fb[len - 1] == pfp_pkg::SYNC_BYTE) fb[len - 1] = cks - 8'd1;
        end
        cut = (flaw == FRAME_CUT) ? $urandom_range(1, len - 1) : len;
        for (i = 0; i < cut; i++) send_byte(fb[i]);
        frame_beats += cut;
    endtask

    task automatic run_random(input int unsigned beats);
        int unsigned target;
        int unsigned pick;
        target = frame_beats + beats;
        while (frame_beats < target)
        begin
            pick = $urandom_range(99);
            if (pick < 70) send_frame(1'($urandom_range(1)), FRAME_CLEAN, 1'b0, 8'h00);
            else if (pick < 78) send_frame(1'($urandom_range(1)), FRAME_BAD_SUM, 1'b0, 8'h00);
            else if (pick < 84) send_frame(1'($urandom_range(1)), FRAME_BAD_HEADER, 1'b0, 8'h00);
            else if (pick < 90) send_frame(1'($urandom_range(1)), FRAME_CUT, 1'b0, 8'h00);
            else send_run($urandom_range(1, 6), 1'b1);
            if ($urandom_range(3) == 0) send_run($urandom_range(1, 8), 1'b0);
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // drop bytes before sync, then a kept nine-byte frame running on to
        // position thirteen with the wrong header, then a cleared thirteen-byte frame
        send_byte(8'h00);
        send_byte(8'h80);
        send_frame(1'b0, FRAME_CLEAN, 1'b1, 8'hfe);
        send_byte(8'h01);
        send_byte(8'h7f);
        send_byte(8'hfe);
        send_byte(8'h00);
        send_frame(1'b1, FRAME_CLEAN, 1'b1, 8'h00);

        hold_request = 1'b1;
        run_random(100);

        send_idle_pct  = 67;
        recv_stall_pct = 0;
        run_random(100);

        send_idle_pct  = 0;
        recv_stall_pct = 67;
        run_random(100);

        send_idle_pct  = 13;
        recv_stall_pct = 13;
        run_random(100);

        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.pending.size() == 0)
            $display("pressure_frame_parser: match");
        else
            $display("pressure_frame_parser: mismatch");
        $finish;
    end

endmodule

FILE: filelist.f
sv/pfp_pkg.sv
sv/pressure_frame_parser.sv
tb/tb_pressure_frame_parser.sv
